>>> hdl/jddm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jddm_pkg;

  localparam int RAW_W      = 16;
  localparam int LIM_W      = 16;
  localparam int NORM_W     = 19;
  localparam int MAG_W      = 18;
  localparam int PROD_W     = 34;
  localparam int DEN_W      = 17;
  localparam int QUO_W      = PROD_W;
  localparam int SPD_W      = 17;
  localparam int SUM_W      = QUO_W + 2;
  localparam int DIV_STAGES = QUO_W;
  localparam int CFG_IDX_W  = 3;

  // floor(z / 10) = (z * RECIP10) >> RECIP_SHIFT, exact for z below 2^18
  localparam logic [16:0] RECIP10     = 17'd104858;
  localparam int          RECIP_SHIFT = 20;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_MIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_MAX       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_CENTER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_LEFT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_RIGHT   = 3'd6;

  localparam logic [RAW_W-1:0] RST_AXIS_MIN       = 16'd0;
  localparam logic [RAW_W-1:0] RST_AXIS_MAX       = 16'd4095;
  localparam logic [RAW_W-1:0] RST_AXIS_CENTER    = 16'd2048;
  localparam logic [RAW_W-1:0] RST_DEAD_BAND      = 16'd100;
  localparam logic [RAW_W-1:0] RST_VELOCITY_LIMIT = 16'd3000;

  typedef struct packed {
    logic [RAW_W-1:0] axis_min;
    logic [RAW_W-1:0] axis_max;
    logic [RAW_W-1:0] axis_center;
    logic [RAW_W-1:0] dead_band;
    logic [RAW_W-1:0] velocity_limit;
    logic             invert_left;
    logic             invert_right;
  } cfg_t;

  // per-sample control that rides alongside the quotient bits
  typedef struct packed {
    logic             span_ok;
    logic             fwd;
    logic             bwd;
    logic             x_pos;
    logic             x_neg;
    logic             y_neg;
    logic [LIM_W-1:0] lim;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [PROD_W-1:0] num_x;
    logic [PROD_W-1:0] num_y;
    logic [DEN_W-1:0]  den;
  } div_in_t;

  typedef struct packed {
    side_t            side;
    logic [QUO_W-1:0] quo_x;
    logic [QUO_W-1:0] quo_y;
  } div_out_t;

endpackage

`default_nettype wire

>>> hdl/jddm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface jddm_in_if;
  logic                         valid;
  logic                         ready;
  logic [jddm_pkg::RAW_W-1:0]   stick_x;
  logic [jddm_pkg::RAW_W-1:0]   stick_y;
  logic                         fast_mode;
  modport source  (output valid, stick_x, stick_y, fast_mode, input ready);
  modport sink    (input valid, stick_x, stick_y, fast_mode, output ready);
  modport monitor (input valid, ready, stick_x, stick_y, fast_mode);
endinterface

interface jddm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [jddm_pkg::SPD_W-1:0] left_speed;
  logic signed [jddm_pkg::SPD_W-1:0] right_speed;
  modport source  (output valid, left_speed, right_speed, input ready);
  modport sink    (input valid, left_speed, right_speed, output ready);
  modport monitor (input valid, ready, left_speed, right_speed);
endinterface

interface jddm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [jddm_pkg::CFG_IDX_W-1:0]   index;
  logic [jddm_pkg::RAW_W-1:0]       data;
  modport source  (output valid, index, data, input ready);
  modport sink    (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

`default_nettype wire

>>> hdl/jddm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module jddm_cfg (
  input  wire              clk_i,
  input  wire              rst_ni,
  jddm_cfg_if.sink         cfg_i,
  output jddm_pkg::cfg_t   cfg_o
);

  jddm_pkg::cfg_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.axis_min       <= jddm_pkg::RST_AXIS_MIN;
      regs_q.axis_max       <= jddm_pkg::RST_AXIS_MAX;
      regs_q.axis_center    <= jddm_pkg::RST_AXIS_CENTER;
      regs_q.dead_band      <= jddm_pkg::RST_DEAD_BAND;
      regs_q.velocity_limit <= jddm_pkg::RST_VELOCITY_LIMIT;
      regs_q.invert_left    <= 1'b0;
      regs_q.invert_right   <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        jddm_pkg::REG_AXIS_MIN:       regs_q.axis_min       <= cfg_i.data;
        jddm_pkg::REG_AXIS_MAX:       regs_q.axis_max       <= cfg_i.data;
        jddm_pkg::REG_AXIS_CENTER:    regs_q.axis_center    <= cfg_i.data;
        jddm_pkg::REG_DEAD_BAND:      regs_q.dead_band      <= cfg_i.data;
        jddm_pkg::REG_VELOCITY_LIMIT: regs_q.velocity_limit <= cfg_i.data;
        jddm_pkg::REG_INVERT_LEFT:    regs_q.invert_left    <= cfg_i.data[0];
        jddm_pkg::REG_INVERT_RIGHT:   regs_q.invert_right   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/jddm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module jddm_front (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            adv_i,
  input  wire                            valid_i,
  input  wire [jddm_pkg::RAW_W-1:0]      stick_x_i,
  input  wire [jddm_pkg::RAW_W-1:0]      stick_y_i,
  input  wire                            fast_mode_i,
  input  jddm_pkg::cfg_t                 cfg_i,
  output logic                           valid_o,
  output jddm_pkg::div_in_t              div_o
);

  localparam int TEN_W = jddm_pkg::NORM_W + 4;

  // normalized numerator 2*(raw - min) - span, zero inside the dead band
  function automatic logic signed [jddm_pkg::NORM_W-1:0] norm_axis(
    input logic [jddm_pkg::RAW_W-1:0] raw,
    input logic [jddm_pkg::RAW_W-1:0] center,
    input logic [jddm_pkg::RAW_W-1:0] dband,
    input logic [jddm_pkg::RAW_W-1:0] amin,
    input logic [jddm_pkg::RAW_W-1:0] span
  );
    logic signed [jddm_pkg::RAW_W:0]    dc;
    logic signed [jddm_pkg::RAW_W:0]    off;
    logic [jddm_pkg::RAW_W:0]           adc;
    logic signed [jddm_pkg::NORM_W-1:0] n;
    dc  = $signed({1'b0, raw}) - $signed({1'b0, center});
    adc = dc[jddm_pkg::RAW_W] ? 17'(-dc) : 17'(dc);
    off = $signed({1'b0, raw}) - $signed({1'b0, amin});
    n   = (jddm_pkg::NORM_W'(off) <<< 1)
          - $signed({{(jddm_pkg::NORM_W - jddm_pkg::RAW_W){1'b0}}, span});
    return (adc < {1'b0, dband}) ? '0 : n;
  endfunction

  // stage 1: normalize both axes, derive the limit
  logic                               v1_q;
  logic                               fast1_q;
  logic                               ok1_q;
  logic [jddm_pkg::RAW_W-1:0]         span1_q;
  logic signed [jddm_pkg::NORM_W-1:0] nx1_q;
  logic signed [jddm_pkg::NORM_W-1:0] ny1_q;
  logic [jddm_pkg::LIM_W-1:0]         lim1_q;

  logic signed [jddm_pkg::RAW_W:0]    span_d;
  logic [jddm_pkg::RAW_W:0]           vl9_d;
  logic [jddm_pkg::PROD_W-1:0]        rp_d;
  logic [jddm_pkg::LIM_W-1:0]         lim_d;

  always_comb begin
    span_d = $signed({1'b0, cfg_i.axis_max}) - $signed({1'b0, cfg_i.axis_min});
    // floor(9v/10) = v - ceil(v/10) = v - floor((v+9)/10)
    vl9_d  = {1'b0, cfg_i.velocity_limit} + 17'd9;
    rp_d   = jddm_pkg::PROD_W'(vl9_d) * jddm_pkg::PROD_W'(jddm_pkg::RECIP10);
    if (fast_mode_i) begin
      lim_d = cfg_i.velocity_limit
              - jddm_pkg::LIM_W'(rp_d[jddm_pkg::PROD_W-1:jddm_pkg::RECIP_SHIFT]);
    end else begin
      lim_d = cfg_i.velocity_limit >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fast1_q <= fast_mode_i;
      ok1_q   <= !span_d[jddm_pkg::RAW_W] && (span_d != '0);
      span1_q <= span_d[jddm_pkg::RAW_W-1:0];
      lim1_q  <= lim_d;
      nx1_q   <= norm_axis(stick_x_i, cfg_i.axis_center, cfg_i.dead_band,
                           cfg_i.axis_min, span_d[jddm_pkg::RAW_W-1:0]);
      ny1_q   <= norm_axis(stick_y_i, cfg_i.axis_center, cfg_i.dead_band,
                           cfg_i.axis_min, span_d[jddm_pkg::RAW_W-1:0]);
    end
  end

  // stage 2: scale magnitudes by the limit, pick the drive band
  logic [jddm_pkg::MAG_W-1:0]   mag_x_d;
  logic [jddm_pkg::MAG_W-1:0]   mag_y_d;
  logic signed [TEN_W-1:0]      ten_ny_d;
  logic signed [TEN_W-1:0]      span_s_d;
  jddm_pkg::div_in_t            div_d;
  logic                         v2_q;
  jddm_pkg::div_in_t            div2_q;

  always_comb begin
    mag_x_d  = nx1_q[jddm_pkg::NORM_W-1] ? jddm_pkg::MAG_W'(-nx1_q)
                                         : jddm_pkg::MAG_W'(nx1_q);
    mag_y_d  = ny1_q[jddm_pkg::NORM_W-1] ? jddm_pkg::MAG_W'(-ny1_q)
                                         : jddm_pkg::MAG_W'(ny1_q);
    ten_ny_d = (TEN_W'(ny1_q) <<< 3) + (TEN_W'(ny1_q) <<< 1);
    span_s_d = $signed({{(TEN_W - jddm_pkg::RAW_W){1'b0}}, span1_q});

    div_d.side.span_ok = ok1_q;
    div_d.side.fwd     = ten_ny_d >= span_s_d;
    div_d.side.bwd     = ten_ny_d <= -span_s_d;
    div_d.side.x_pos   = !nx1_q[jddm_pkg::NORM_W-1] && (nx1_q != '0);
    div_d.side.x_neg   = nx1_q[jddm_pkg::NORM_W-1];
    div_d.side.y_neg   = ny1_q[jddm_pkg::NORM_W-1];
    div_d.side.lim     = lim1_q;
    div_d.num_x        = jddm_pkg::PROD_W'(mag_x_d) * jddm_pkg::PROD_W'(lim1_q);
    div_d.num_y        = jddm_pkg::PROD_W'(mag_y_d) * jddm_pkg::PROD_W'(lim1_q);
    div_d.den          = fast1_q ? {1'b0, span1_q} : {span1_q, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      div2_q <= div_d;
    end
  end

  assign valid_o = v2_q;
  assign div_o   = div2_q;

endmodule

`default_nettype wire

>>> hdl/jddm_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-lane restoring divider, one quotient bit per stage, shared divisor.
module jddm_div (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    adv_i,
  input  wire                    valid_i,
  input  jddm_pkg::div_in_t      div_i,
  output logic                   valid_o,
  output jddm_pkg::div_out_t     div_o
);

  localparam int NS   = jddm_pkg::DIV_STAGES;
  localparam int DW   = jddm_pkg::DEN_W;
  localparam int QW   = jddm_pkg::QUO_W;
  localparam int LANE = 2;

  logic [NS-1:0]          vld_q;
  jddm_pkg::side_t        side_q [NS];
  logic [DW-1:0]          den_q  [NS];
  logic [DW-1:0]          rem_q  [NS][LANE];
  logic [QW-1:0]          acc_q  [NS][LANE];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    jddm_pkg::side_t side_in;
    logic [DW-1:0]   den_in;
    logic            vld_in;

    if (s == 0) begin : g_first
      assign side_in = div_i.side;
      assign den_in  = div_i.den;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign side_in = side_q[s-1];
      assign den_in  = den_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    for (genvar l = 0; l < LANE; l++) begin : g_lane
      logic [DW-1:0] rem_in;
      logic [QW-1:0] acc_in;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW:0]   diff;

      if (s == 0) begin : g_first
        assign rem_in = '0;
        assign acc_in = (l == 0) ? div_i.num_x : div_i.num_y;
      end else begin : g_next
        assign rem_in = rem_q[s-1][l];
        assign acc_in = acc_q[s-1][l];
      end

      always_comb begin
        trial = {rem_in, acc_in[QW-1]};
        ge    = trial >= {1'b0, den_in};
        diff  = ge ? (trial - {1'b0, den_in}) : trial;
      end

      // shift the next dividend bit in, the quotient bit in at the bottom
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[s][l] <= diff[DW-1:0];
          acc_q[s][l] <= {acc_in[QW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        side_q[s] <= side_in;
        den_q[s]  <= den_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s] <= vld_in;
      end
    end
  end

  assign valid_o     = vld_q[NS-1];
  assign div_o.side  = side_q[NS-1];
  assign div_o.quo_x = acc_q[NS-1][0];
  assign div_o.quo_y = acc_q[NS-1][1];

endmodule

`default_nettype wire

>>> hdl/jddm_mix.sv
`timescale 1ns / 1ps
`default_nettype none

module jddm_mix (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              adv_i,
  input  wire                              valid_i,
  input  jddm_pkg::div_out_t               div_i,
  input  wire                              invert_left_i,
  input  wire                              invert_right_i,
  output logic                             valid_o,
  output logic signed [jddm_pkg::SPD_W-1:0] left_o,
  output logic signed [jddm_pkg::SPD_W-1:0] right_o
);

  localparam int SW = jddm_pkg::SUM_W;
  localparam int QW = jddm_pkg::QUO_W;

  // stage A: sign the quotients and mix
  logic signed [SW-1:0] turn_d;
  logic signed [SW-1:0] drive_d;
  logic signed [SW-1:0] left_d;
  logic signed [SW-1:0] right_d;

  logic                       va_q;
  logic                       ok_a_q;
  logic [jddm_pkg::LIM_W-1:0] lim_a_q;
  logic signed [SW-1:0]       left_a_q;
  logic signed [SW-1:0]       right_a_q;

  always_comb begin
    turn_d  = $signed({{(SW - QW){1'b0}}, div_i.quo_x});
    drive_d = $signed({{(SW - QW){1'b0}}, div_i.quo_y});
    if (div_i.side.x_neg) turn_d  = -turn_d;
    if (div_i.side.y_neg) drive_d = -drive_d;

    if (div_i.side.fwd) begin
      if (!div_i.side.x_pos) begin
        right_d = drive_d;
        left_d  = drive_d + turn_d;
      end else begin
        left_d  = drive_d;
        right_d = drive_d - turn_d;
      end
    end else if (div_i.side.bwd) begin
      if (!div_i.side.x_pos) begin
        right_d = drive_d;
        left_d  = drive_d - turn_d;
      end else begin
        left_d  = drive_d;
        right_d = drive_d + turn_d;
      end
    end else begin
      // pivot in place
      left_d  = turn_d;
      right_d = -turn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ok_a_q    <= div_i.side.span_ok;
      lim_a_q   <= div_i.side.lim;
      left_a_q  <= left_d;
      right_a_q <= right_d;
    end
  end

  // stage B: clamp, invert, zero on an empty span, register the output beat
  function automatic logic signed [jddm_pkg::SPD_W-1:0] wheel(
    input logic signed [SW-1:0]       v,
    input logic [jddm_pkg::LIM_W-1:0] lim,
    input logic                       inv,
    input logic                       ok
  );
    logic signed [SW-1:0]             lim_s;
    logic signed [SW-1:0]             c;
    logic signed [jddm_pkg::SPD_W-1:0] w;
    lim_s = $signed({{(SW - jddm_pkg::LIM_W){1'b0}}, lim});
    if (v > lim_s) begin
      c = lim_s;
    end else if (v < -lim_s) begin
      c = -lim_s;
    end else begin
      c = v;
    end
    w = c[jddm_pkg::SPD_W-1:0];
    if (inv) w = -w;
    return ok ? w : '0;
  endfunction

  logic                              vb_q;
  logic signed [jddm_pkg::SPD_W-1:0] left_q;
  logic signed [jddm_pkg::SPD_W-1:0] right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      left_q  <= wheel(left_a_q, lim_a_q, invert_left_i, ok_a_q);
      right_q <= wheel(right_a_q, lim_a_q, invert_right_i, ok_a_q);
    end
  end

  assign valid_o = vb_q;
  assign left_o  = left_q;
  assign right_o = right_q;

endmodule

`default_nettype wire

>>> hdl/joystick_differential_drive_mixer.sv
`timescale 1ns / 1ps
`default_nettype none

// Differential-drive joystick mixer: each beat on in_i (stick_x, stick_y,
// fast_mode) yields exactly one beat on out_o with the left and right wheel
// velocities in two's complement rpm. The block takes one sample per clock
// when not stalled: stages 1 and 2 normalize and scale the axes, the two
// divider lanes produce one quotient bit per stage over 34 stages, and
// stages A and B mix, clamp and invert. The whole pipeline holds while an
// output beat waits, so in_i.ready is low exactly when out_o is valid and
// not taken. Registers on cfg_i (always ready) are indexed axis_min, axis_max,
// axis_center, dead_band, velocity_limit, invert_left, invert_right from 0;
// other indexes are ignored. Write them only with no sample in flight.
module joystick_differential_drive_mixer (
  input  wire          clk_i,
  input  wire          rst_ni,
  jddm_in_if.sink      in_i,
  jddm_out_if.source   out_o,
  jddm_cfg_if.sink     cfg_i
);

  jddm_pkg::cfg_t      cfg;
  logic                adv;
  logic                front_valid;
  jddm_pkg::div_in_t   front_div;
  logic                div_valid;
  jddm_pkg::div_out_t  div_res;
  logic                mix_valid;

  // advance everything unless the output beat is stuck
  assign adv        = !mix_valid || out_o.ready;
  assign in_i.ready = adv;
  assign out_o.valid = mix_valid;

  jddm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  jddm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (in_i.valid),
    .stick_x_i   (in_i.stick_x),
    .stick_y_i   (in_i.stick_y),
    .fast_mode_i (in_i.fast_mode),
    .cfg_i       (cfg),
    .valid_o     (front_valid),
    .div_o       (front_div)
  );

  jddm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (front_valid),
    .div_i   (front_div),
    .valid_o (div_valid),
    .div_o   (div_res)
  );

  jddm_mix u_mix (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .valid_i        (div_valid),
    .div_i          (div_res),
    .invert_left_i  (cfg.invert_left),
    .invert_right_i (cfg.invert_right),
    .valid_o        (mix_valid),
    .left_o         (out_o.left_speed),
    .right_o        (out_o.right_speed)
  );

endmodule

`default_nettype wire

>>> hdl/jddm_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module jddm_chk (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       in_ready_i,
  input wire                       out_valid_i,
  input wire                       out_ready_i,
  input wire [jddm_pkg::SPD_W-1:0] left_speed_i,
  input wire [jddm_pkg::SPD_W-1:0] right_speed_i
);

  localparam logic [jddm_pkg::SPD_W-1:0] MOST_NEG = {1'b1, {(jddm_pkg::SPD_W-1){1'b0}}};

  // a waiting beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // the pipeline does not move under a stalled output
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(left_speed_i) && $stable(right_speed_i))
    else $error("output payload changed while stalled");

  // clamped wheels never reach the most negative code
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (left_speed_i != MOST_NEG) && (right_speed_i != MOST_NEG))
    else $error("wheel speed out of range");

  // input side is throttled only by a stuck output beat
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output backpressure");

endmodule

bind joystick_differential_drive_mixer jddm_chk u_jddm_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .left_speed_i  (out_o.left_speed),
  .right_speed_i (out_o.right_speed)
);

`default_nettype wire

>>> bench/joystick_differential_drive_mixer_tb.sv
`timescale 1ns / 1ps

module joystick_differential_drive_mixer_tb;

  // one past the last register, must be ignored by the block
  localparam logic [jddm_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

  localparam int MAX_CYCLES    = 200000;
  localparam int SETTLE_CYCLES = 60;
  localparam int SHOWN_ERRORS  = 10;

  typedef struct packed {
    logic signed [jddm_pkg::SPD_W-1:0] left;
    logic signed [jddm_pkg::SPD_W-1:0] right;
  } wheels_t;

  logic clk;
  logic rst_n;

  jddm_in_if  in_if ();
  jddm_out_if out_if ();
  jddm_cfg_if cfg_if ();

  joystick_differential_drive_mixer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  jddm_pkg::cfg_t shadow_cfg;
  wheels_t        pending_wheels[$];
  int             mismatch_count = 0;
  int             cycle_count = 0;
  bit             tx_gaps = 1'b0;
  bit             rx_stalls = 1'b0;
  bit             rx_hold = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // wheel velocity predictor

  function automatic longint axis_numerator(jddm_pkg::cfg_t c,
                                            logic [jddm_pkg::RAW_W-1:0] raw,
                                            longint span);
    longint off;
    off = longint'(raw) - longint'(c.axis_center);
    if (off < 0) off = -off;
    if (off < longint'(c.dead_band)) return 0;
    return 2 * (longint'(raw) - longint'(c.axis_min)) - span;
  endfunction

  function automatic longint clamp_rpm(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic wheels_t predict_wheels(jddm_pkg::cfg_t c,
                                             logic [jddm_pkg::RAW_W-1:0] sx,
                                             logic [jddm_pkg::RAW_W-1:0] sy, logic fast);
    longint span, lim, den, nx, ny, turn, drive, left, right;
    wheels_t w;
    span = longint'(c.axis_max) - longint'(c.axis_min);
    left = 0;
    right = 0;
    if (span > 0) begin
      lim = fast ? longint'(c.velocity_limit) * 9 / 10 : longint'(c.velocity_limit) / 2;
      den = fast ? span : 2 * span;
      nx = axis_numerator(c, sx, span);
      ny = axis_numerator(c, sy, span);
      turn = nx * lim / den;
      drive = ny * lim / den;
      if (10 * ny >= span) begin
        if (nx <= 0) begin
          right = drive;
          left = drive + turn;
        end else begin
          left = drive;
          right = drive - turn;
        end
      end else if (10 * ny <= -span) begin
        if (nx <= 0) begin
          right = drive;
          left = drive - turn;
        end else begin
          left = drive;
          right = drive + turn;
        end
      end else begin
        // pivot in place
        left = turn;
        right = -turn;
      end
      left = clamp_rpm(left, lim);
      right = clamp_rpm(right, lim);
      if (c.invert_left) left = -left;
      if (c.invert_right) right = -right;
    end
    w.left = left[jddm_pkg::SPD_W-1:0];
    w.right = right[jddm_pkg::SPD_W-1:0];
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // settings

  function automatic jddm_pkg::cfg_t make_settings(logic [jddm_pkg::RAW_W-1:0] lo,
                                                   logic [jddm_pkg::RAW_W-1:0] hi,
                                                   logic [jddm_pkg::RAW_W-1:0] cen,
                                                   logic [jddm_pkg::RAW_W-1:0] db,
                                                   logic [jddm_pkg::RAW_W-1:0] vl,
                                                   bit il, bit ir);
    jddm_pkg::cfg_t c;
    c.axis_min = lo;
    c.axis_max = hi;
    c.axis_center = cen;
    c.dead_band = db;
    c.velocity_limit = vl;
    c.invert_left = il;
    c.invert_right = ir;
    return c;
  endfunction

  function automatic jddm_pkg::cfg_t reset_settings();
    return make_settings(jddm_pkg::RST_AXIS_MIN, jddm_pkg::RST_AXIS_MAX,
                         jddm_pkg::RST_AXIS_CENTER, jddm_pkg::RST_DEAD_BAND,
                         jddm_pkg::RST_VELOCITY_LIMIT, 1'b0, 1'b0);
  endfunction

  function automatic jddm_pkg::cfg_t random_settings();
    int lo, hi, cen, db, vl;
    case ($urandom_range(0, 9))
      0, 1: begin
        lo = 0;
        hi = 4095;
      end
      2, 3: begin
        lo = 0;
        hi = 65535;
      end
      4: begin
        // tiny span
        lo = $urandom_range(0, 65000);
        hi = lo + $urandom_range(1, 20);
      end
      5: begin
        // empty span
        lo = $urandom_range(1, 65535);
        hi = $urandom_range(0, lo);
      end
      default: begin
        lo = $urandom_range(0, 32767);
        hi = lo + $urandom_range(1, 65535 - lo);
      end
    endcase
    if ($urandom_range(0, 4) == 0) cen = $urandom_range(0, 65535);
    else cen = lo + (hi - lo) / 2 + int'($urandom_range(0, 200)) - 100;
    if (cen < 0) cen = 0;
    else if (cen > 65535) cen = 65535;
    if ($urandom_range(0, 5) == 0) db = $urandom_range(0, 65535);
    else if (hi > lo) db = $urandom_range(0, (hi - lo) / 8 + 1);
    else db = $urandom_range(0, 300);
    case ($urandom_range(0, 5))
      0: vl = 0;
      1: vl = 65535;
      default: vl = $urandom_range(0, 65535);
    endcase
    return make_settings(lo[jddm_pkg::RAW_W-1:0], hi[jddm_pkg::RAW_W-1:0],
                         cen[jddm_pkg::RAW_W-1:0], db[jddm_pkg::RAW_W-1:0],
                         vl[jddm_pkg::RAW_W-1:0], 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [jddm_pkg::RAW_W-1:0] pick_axis(jddm_pkg::cfg_t c);
    int span, v;
    span = int'(c.axis_max) - int'(c.axis_min);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        if (span > 0) v = int'(c.axis_min) + int'($urandom_range(0, span));
        else v = $urandom_range(0, 65535);
      end
      6: v = int'(c.axis_center) + int'($urandom_range(0, 2 * c.dead_band + 4))
             - int'(c.dead_band) - 2;
      // around the edge of the pivot band
      7: v = int'(c.axis_min) + span / 2 + ($urandom_range(0, 1) ? span / 20 : -span / 20)
             + int'($urandom_range(0, 6)) - 3;
      default: v = $urandom_range(0, 65535);
    endcase
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return v[jddm_pkg::RAW_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // drivers

  task automatic write_reg(input logic [jddm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [jddm_pkg::RAW_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      jddm_pkg::REG_AXIS_MIN:       shadow_cfg.axis_min = value;
      jddm_pkg::REG_AXIS_MAX:       shadow_cfg.axis_max = value;
      jddm_pkg::REG_AXIS_CENTER:    shadow_cfg.axis_center = value;
      jddm_pkg::REG_DEAD_BAND:      shadow_cfg.dead_band = value;
      jddm_pkg::REG_VELOCITY_LIMIT: shadow_cfg.velocity_limit = value;
      jddm_pkg::REG_INVERT_LEFT:    shadow_cfg.invert_left = value[0];
      jddm_pkg::REG_INVERT_RIGHT:   shadow_cfg.invert_right = value[0];
      default: ;
    endcase
  endtask

  task automatic drain_wheels();
    in_if.valid <= 1'b0;
    while (pending_wheels.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input jddm_pkg::cfg_t c);
    drain_wheels();
    write_reg(jddm_pkg::REG_AXIS_MIN, c.axis_min);
    write_reg(jddm_pkg::REG_AXIS_MAX, c.axis_max);
    write_reg(jddm_pkg::REG_AXIS_CENTER, c.axis_center);
    write_reg(jddm_pkg::REG_DEAD_BAND, c.dead_band);
    write_reg(jddm_pkg::REG_VELOCITY_LIMIT, c.velocity_limit);
    write_reg(jddm_pkg::REG_INVERT_LEFT, jddm_pkg::RAW_W'(c.invert_left));
    write_reg(jddm_pkg::REG_INVERT_RIGHT, jddm_pkg::RAW_W'(c.invert_right));
    cfg_if.valid <= 1'b0;
  endtask

  // valid stays high after a beat so the next one can follow without a bubble
  task automatic send_sample(input logic [jddm_pkg::RAW_W-1:0] sx,
                             input logic [jddm_pkg::RAW_W-1:0] sy,
                             input logic fast);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.stick_x <= sx;
    in_if.stick_y <= sy;
    in_if.fast_mode <= fast;
    do @(posedge clk); while (!in_if.ready);
    pending_wheels.push_back(predict_wheels(shadow_cfg, sx, sy, fast));
  endtask

  task automatic hold_receiver(input int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  initial begin : drive_out_ready
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) stall_left = rx_stalls ? $urandom_range(0, 3) : 0;
      if (rx_hold || !rst_n) begin
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checking

  function automatic void note_failure(string what);
    mismatch_count++;
    if (mismatch_count <= SHOWN_ERRORS) $display("ERROR @%0t: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin : check_wheels
    wheels_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_wheels.size() == 0) begin
        note_failure($sformatf("beat with nothing pending: left %0d right %0d",
                               out_if.left_speed, out_if.right_speed));
      end else begin
        want = pending_wheels.pop_front();
        if (out_if.left_speed !== want.left)
          note_failure($sformatf("left_speed expected %0d got %0d",
                                 want.left, out_if.left_speed));
        if (out_if.right_speed !== want.right)
          note_failure($sformatf("right_speed expected %0d got %0d",
                                 want.right, out_if.right_speed));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("watchdog expired after %0d cycles, %0d beats pending",
               cycle_count, pending_wheels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests

  task automatic test_directed();
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    send_sample(16'd2048, 16'd2048, 1'b1);
    send_sample(16'd2048, 16'd2048, 1'b0);
    send_sample(16'd0, 16'd0, 1'b1);
    send_sample(16'd65535, 16'd65535, 1'b1);
    send_sample(16'd65535, 16'd0, 1'b0);
    send_sample(16'd0, 16'd65535, 1'b0);
    send_sample(16'd4095, 16'd4095, 1'b1);
    send_sample(16'd1000, 16'd4000, 1'b1);
    send_sample(16'd3500, 16'd4000, 1'b0);
    send_sample(16'd500, 16'd100, 1'b1);
    send_sample(16'd3800, 16'd300, 1'b0);
    send_sample(16'd4000, 16'd2200, 1'b1);
    send_sample(16'd300, 16'd1900, 1'b0);
    // either side of the pivot band edges
    send_sample(16'd3000, 16'd2253, 1'b1);
    send_sample(16'd3000, 16'd2252, 1'b1);
    send_sample(16'd1000, 16'd1842, 1'b1);
    send_sample(16'd1000, 16'd1843, 1'b1);
    // either side of the dead band edges
    send_sample(16'd2148, 16'd3000, 1'b1);
    send_sample(16'd2147, 16'd3000, 1'b1);
    send_sample(16'd1948, 16'd1000, 1'b0);
    send_sample(16'd1949, 16'd1000, 1'b0);
    send_sample(16'h5555, 16'hAAAA, 1'b1);
  endtask

  task automatic test_register_writes();
    load_settings(make_settings(16'd100, 16'd3100, 16'd1600, 16'd50, 16'd10000, 1'b1, 1'b1));
    send_sample(16'd3000, 16'd3000, 1'b1);
    send_sample(16'd200, 16'd200, 1'b0);
    send_sample(16'd2500, 16'd1600, 1'b1);
    send_sample(16'd700, 16'd1600, 1'b0);
    drain_wheels();
    write_reg(REG_NONE, 16'hFFFF);
    // only bit 0 lands in a one-bit register
    write_reg(jddm_pkg::REG_INVERT_LEFT, 16'hFFFE);
    cfg_if.valid <= 1'b0;
    send_sample(16'd3000, 16'd3000, 1'b1);
    send_sample(16'd200, 16'd200, 1'b1);
    send_sample(16'd2500, 16'd1600, 1'b0);
    // empty span, zero width then inverted bounds
    load_settings(make_settings(16'd2000, 16'd2000, 16'd2000, 16'd0, 16'd3000, 1'b0, 1'b0));
    send_sample(16'd0, 16'd65535, 1'b1);
    send_sample(16'd4000, 16'd0, 1'b0);
    load_settings(make_settings(16'd4000, 16'd100, 16'd2000, 16'd0, 16'd3000, 1'b1, 1'b0));
    send_sample(16'd3900, 16'd3900, 1'b1);
    send_sample(16'd150, 16'd2000, 1'b0);
  endtask

  task automatic test_extreme_settings();
    jddm_pkg::cfg_t corner[6];
    corner[0] = make_settings(16'd0, 16'd65535, 16'd32768, 16'd0, 16'd65535, 1'b0, 1'b0);
    corner[1] = make_settings(16'd0, 16'd65535, 16'd32768, 16'd1000, 16'd0, 1'b1, 1'b1);
    corner[2] = make_settings(16'd0, 16'd4095, 16'd2048, 16'd65535, 16'd3000, 1'b0, 1'b0);
    corner[3] = make_settings(16'd0, 16'd1, 16'd0, 16'd0, 16'd65535, 1'b1, 1'b0);
    corner[4] = make_settings(16'd1000, 16'd5000, 16'd0, 16'd10, 16'd1, 1'b0, 1'b1);
    corner[5] = make_settings(16'd0, 16'd65535, 16'd65535, 16'd0, 16'd65534, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++) begin
      load_settings(corner[i]);
      send_sample(16'd0, 16'd0, 1'b1);
      send_sample(16'd65535, 16'd65535, 1'b0);
      for (int k = 0; k < 13; k++)
        send_sample(pick_axis(shadow_cfg), pick_axis(shadow_cfg), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_input_backpressure();
    load_settings(make_settings(16'd0, 16'd65535, 16'd32768, 16'd500, 16'd20000, 1'b0, 1'b1));
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    // hold the output long enough for the pipeline to fill and stall the input
    fork
      hold_receiver(300);
    join_none
    for (int k = 0; k < 100; k++)
      send_sample(pick_axis(shadow_cfg), pick_axis(shadow_cfg), 1'($urandom_range(0, 1)));
    drain_wheels();
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    for (int k = 0; k < 30; k++)
      send_sample(pick_axis(shadow_cfg), pick_axis(shadow_cfg), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_phases();
    int n;
    for (int phase = 0; phase < 20; phase++) begin
      load_settings(random_settings());
      tx_gaps = (phase != 0) && ($urandom_range(0, 3) != 0);
      rx_stalls = (phase != 0) && ($urandom_range(0, 3) != 0);
      n = $urandom_range(38, 54);
      for (int k = 0; k < n; k++) begin
        send_sample(pick_axis(shadow_cfg), pick_axis(shadow_cfg), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 99) == 0) drain_wheels();
      end
    end
  endtask

  initial begin : run_tests
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.stick_x <= '0;
    in_if.stick_y <= '0;
    in_if.fast_mode <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    shadow_cfg = reset_settings();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_writes();
    test_extreme_settings();
    test_input_backpressure();
    test_random_phases();
    drain_wheels();
    // catch any stray beats behind the last one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
